/* sv/hvsp_pkg.sv */
`default_nettype none
package hvsp_pkg;

  // Item kinds as they arrive on the input channel.
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Command codes.
  localparam logic [1:0] OP_SIG = 2'd0;
  localparam logic [1:0] OP_RDF = 2'd1;
  localparam logic [1:0] OP_WRF = 2'd2;

  // Fuse codes.
  localparam logic [1:0] FUSE_LOW  = 2'd0;
  localparam logic [1:0] FUSE_HIGH = 2'd1;
  localparam logic [1:0] FUSE_EXT  = 2'd2;

  // Frame layout: start bit, eight payload bits, two trailing zeros.
  localparam logic [3:0] BIT_DATA_FIRST = 4'd1;
  localparam logic [3:0] BIT_DATA_LAST  = 4'd8;
  localparam logic [3:0] BITS_PER_FRAME = 4'd11;

  // Instruction and data bytes of the programming protocol.
  localparam logic [7:0] INS_LOAD_CMD  = 8'h4C;
  localparam logic [7:0] DAT_RD_FUSE   = 8'h04;
  localparam logic [7:0] DAT_RD_SIG    = 8'h08;
  localparam logic [7:0] INS_LOAD_ADDR = 8'h0C;
  localparam logic [7:0] INS_RD_LO_A   = 8'h68;
  localparam logic [7:0] INS_RD_LO_B   = 8'h6C;
  localparam logic [7:0] DAT_WR_FUSE   = 8'h40;
  localparam logic [7:0] INS_LOAD_DATA = 8'h2C;
  localparam logic [7:0] INS_RD_HI_A   = 8'h7A;
  localparam logic [7:0] INS_RD_HI_B   = 8'h7E;
  localparam logic [7:0] INS_RD_EX_A   = 8'h6A;
  localparam logic [7:0] INS_RD_EX_B   = 8'h6E;
  localparam logic [7:0] INS_WR_LO_C   = 8'h64;
  localparam logic [7:0] INS_WR_HI_C   = 8'h74;
  localparam logic [7:0] INS_WR_HI_D   = 8'h7C;
  localparam logic [7:0] INS_WR_EX_C   = 8'h66;
  localparam logic [7:0] WRITE_POLL_FRAME_A = 8'd4;
  localparam logic [7:0] WRITE_POLL_FRAME_B = 8'd5;

  // Queue depths.
  localparam int IQ_DEPTH = 2;
  localparam int OQ_DEPTH = 2;

  typedef enum logic [1:0] {
    CLS_TICK   = 2'd0,
    CLS_START  = 2'd1,
    CLS_IGNORE = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [1:0] op;
    logic [1:0] fuse;
    logic [1:0] sig;
    logic [7:0] wv;
    logic       sdo;
  } item_t;

  typedef struct packed {
    logic       sdi;
    logic       sii;
    logic       sci;
    logic       busy;
    logic       done;
    logic [7:0] read_value;
    logic       rejected;
  } res_t;

  function automatic logic [2:0] total_frames(input logic [1:0] op);
    logic [2:0] n;
    n = 3'd5;
    if (op == OP_SIG) n = 3'd4;
    else if (op == OP_RDF) n = 3'd3;
    return n;
  endfunction

  // Returns {data byte, instruction byte} of frame n; fuse is already clamped.
  function automatic logic [15:0] frame_bytes(input logic [1:0] op, input logic [2:0] n,
                                             input logic [1:0] fuse, input logic [1:0] sig,
                                             input logic [7:0] wv);
    logic [7:0] d;
    logic [7:0] ins;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] e;
    d = 8'h00;
    ins = 8'h00;
    unique case (fuse)
      FUSE_LOW: begin
        a = INS_RD_LO_A; b = INS_RD_LO_B; c = INS_WR_LO_C; e = INS_RD_LO_B;
      end
      FUSE_HIGH: begin
        a = INS_RD_HI_A; b = INS_RD_HI_B; c = INS_WR_HI_C; e = INS_WR_HI_D;
      end
      default: begin
        a = INS_RD_EX_A; b = INS_RD_EX_B; c = INS_WR_EX_C; e = INS_RD_EX_B;
      end
    endcase
    if (op == OP_SIG) begin
      if (n == 3'd0) begin
        d = DAT_RD_SIG; ins = INS_LOAD_CMD;
      end else if (n == 3'd1) begin
        d = {6'd0, sig}; ins = INS_LOAD_ADDR;
      end else if (n == 3'd2) begin
        ins = INS_RD_LO_A;
      end else begin
        ins = INS_RD_LO_B;
      end
    end else if (op == OP_RDF) begin
      if (n == 3'd0) begin
        d = DAT_RD_FUSE; ins = INS_LOAD_CMD;
      end else if (n == 3'd1) begin
        ins = a;
      end else begin
        ins = b;
      end
    end else begin
      if (n == 3'd0) begin
        d = DAT_WR_FUSE; ins = INS_LOAD_CMD;
      end else if (n == 3'd1) begin
        d = wv; ins = INS_LOAD_DATA;
      end else if (n == 3'd2) begin
        ins = c;
      end else if (n == 3'd3) begin
        ins = e;
      end else begin
        ins = INS_LOAD_CMD;
      end
    end
    return {d, ins};
  endfunction

endpackage
`default_nettype wire

/* sv/hvsp_queue.sv */
`default_nettype none
module hvsp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/hvsp_front.sv */
`default_nettype none
module hvsp_front #(
  parameter int DEPTH = hvsp_pkg::IQ_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_kind,
  input  wire logic [1:0]  in_op,
  input  wire logic [1:0]  in_fuse_select,
  input  wire logic [1:0]  in_sig_index,
  input  wire logic [7:0]  in_write_value,
  input  wire logic        in_sdo,
  output hvsp_pkg::item_t  item,
  output logic             item_valid,
  input  wire logic        item_take
);
  import hvsp_pkg::*;

  item_t                cls_item;
  logic [$bits(item_t)-1:0] rd_q;
  logic                 q_empty;

  // Sort the item into tick, valid command start or unusable command, and
  // fold the unused fuse code onto the extended fuse.
  always_comb begin
    cls_item.op   = in_op;
    cls_item.fuse = (in_fuse_select == 2'd3) ? FUSE_EXT : in_fuse_select;
    cls_item.sig  = in_sig_index;
    cls_item.wv   = in_write_value;
    cls_item.sdo  = in_sdo;
    if (in_kind == KIND_TICK) begin
      cls_item.cls = CLS_TICK;
    end else if (in_op <= OP_WRF) begin
      cls_item.cls = CLS_START;
    end else begin
      cls_item.cls = CLS_IGNORE;
    end
  end

  hvsp_queue #(.WIDTH($bits(item_t)), .DEPTH(DEPTH)) u_iq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cls_item),
    .full    (full),
    .rd_en   (item_take),
    .rd_data (rd_q),
    .empty   (q_empty)
  );

  assign item       = item_t'(rd_q);
  assign item_valid = !q_empty;

endmodule
`default_nettype wire

/* sv/hvsp_back.sv */
`default_nettype none
module hvsp_back #(
  parameter int DEPTH = hvsp_pkg::OQ_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hvsp_pkg::item_t  item,
  input  wire logic             item_valid,
  output logic                  item_take,
  output logic                  empty,
  input  wire logic             pop,
  output logic                  out_sdi,
  output logic                  out_sii,
  output logic                  out_sci,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic [7:0]            out_read_value,
  output logic                  out_rejected
);
  import hvsp_pkg::*;

  logic       busy_r, busy_nxt;
  logic [1:0] op_r, op_nxt;
  logic [1:0] fuse_r, fuse_nxt;
  logic [1:0] sig_r, sig_nxt;
  logic [7:0] wv_r, wv_nxt;
  logic [2:0] frame_r, frame_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic       phase_r, phase_nxt;
  logic [7:0] dsh_r, dsh_nxt;
  logic [7:0] ish_r, ish_nxt;
  logic [7:0] rsh_r, rsh_nxt;
  logic       poll_r, poll_nxt;
  logic [7:0] last_r, last_nxt;
  logic       sdi_r, sdi_nxt;
  logic       sii_r, sii_nxt;
  logic       sci_r, sci_nxt;

  logic       oq_full;
  logic       proc;
  logic       done, rej, mid;
  logic [3:0] bit_inc;
  logic [2:0] frame_inc;
  res_t       res;
  logic [$bits(res_t)-1:0] oq_data;
  res_t       oq_res;

  assign proc      = item_valid && !oq_full;
  assign item_take = proc;
  assign mid       = (bit_r >= BIT_DATA_FIRST) && (bit_r <= BIT_DATA_LAST);
  assign bit_inc   = bit_r + 4'd1;
  assign frame_inc = frame_r + 3'd1;

  always_comb begin
    busy_nxt = busy_r;   op_nxt = op_r;     fuse_nxt = fuse_r;  sig_nxt = sig_r;
    wv_nxt = wv_r;       frame_nxt = frame_r; bit_nxt = bit_r;  phase_nxt = phase_r;
    dsh_nxt = dsh_r;     ish_nxt = ish_r;   rsh_nxt = rsh_r;    poll_nxt = poll_r;
    last_nxt = last_r;   sdi_nxt = sdi_r;   sii_nxt = sii_r;    sci_nxt = sci_r;
    done = 1'b0;
    rej  = 1'b0;
    unique case (item.cls)
      CLS_START: begin
        if (busy_r) begin
          rej = 1'b1;
        end else begin
          busy_nxt  = 1'b1;
          op_nxt    = item.op;
          fuse_nxt  = item.fuse;
          sig_nxt   = item.sig;
          wv_nxt    = item.wv;
          frame_nxt = 3'd0;
          bit_nxt   = 4'd0;
          phase_nxt = 1'b0;
          poll_nxt  = 1'b0;
          {dsh_nxt, ish_nxt} = frame_bytes(item.op, 3'd0, item.fuse, item.sig, item.wv);
          rsh_nxt   = 8'd0;
        end
      end
      CLS_IGNORE: begin
        rej = busy_r;
      end
      CLS_TICK: begin
        if (!busy_r) begin
          sdi_nxt = 1'b0; sii_nxt = 1'b0; sci_nxt = 1'b0;
        end else if (poll_r) begin
          sdi_nxt = 1'b0; sii_nxt = 1'b0; sci_nxt = 1'b0;
          if (item.sdo) begin
            poll_nxt = 1'b0;
            if (frame_r >= total_frames(op_r)) begin
              busy_nxt = 1'b0;
              done     = 1'b1;
            end
          end
        end else if (!phase_r) begin
          if (frame_r >= total_frames(op_r)) begin
            busy_nxt = 1'b0;
            done     = 1'b1;
            if (op_r != OP_WRF) last_nxt = rsh_r;
            sdi_nxt = 1'b0; sii_nxt = 1'b0; sci_nxt = 1'b0;
          end else begin
            if (mid) rsh_nxt = {rsh_r[6:0], item.sdo};
            sdi_nxt   = mid && dsh_r[7];
            sii_nxt   = mid && ish_r[7];
            sci_nxt   = 1'b0;
            phase_nxt = 1'b1;
          end
        end else begin
          sci_nxt   = 1'b1;
          phase_nxt = 1'b0;
          if (mid) begin
            dsh_nxt = {dsh_r[6:0], 1'b0};
            ish_nxt = {ish_r[6:0], 1'b0};
          end
          if (bit_inc >= BITS_PER_FRAME) begin
            bit_nxt   = 4'd0;
            frame_nxt = frame_inc;
            if (frame_inc < total_frames(op_r)) begin
              {dsh_nxt, ish_nxt} = frame_bytes(op_r, frame_inc, fuse_r, sig_r, wv_r);
              rsh_nxt = 8'd0;
            end
            if ((op_r == OP_WRF) && ((frame_inc == WRITE_POLL_FRAME_A[2:0]) ||
                                     (frame_inc == WRITE_POLL_FRAME_B[2:0]))) begin
              poll_nxt = 1'b1;
            end
          end else begin
            bit_nxt = bit_inc;
          end
        end
      end
      default: begin
        rej = 1'b0;
      end
    endcase

    res.sdi        = sdi_nxt;
    res.sii        = sii_nxt;
    res.sci        = sci_nxt;
    res.busy       = busy_nxt;
    res.done       = done;
    res.read_value = last_nxt;
    res.rejected   = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;  op_r <= 2'd0;    fuse_r <= 2'd0;  sig_r <= 2'd0;
      wv_r <= 8'd0;    frame_r <= 3'd0; bit_r <= 4'd0;   phase_r <= 1'b0;
      dsh_r <= 8'd0;   ish_r <= 8'd0;   rsh_r <= 8'd0;   poll_r <= 1'b0;
      last_r <= 8'd0;  sdi_r <= 1'b0;   sii_r <= 1'b0;   sci_r <= 1'b0;
    end else if (proc) begin
      busy_r <= busy_nxt;  op_r <= op_nxt;       fuse_r <= fuse_nxt;  sig_r <= sig_nxt;
      wv_r <= wv_nxt;      frame_r <= frame_nxt; bit_r <= bit_nxt;    phase_r <= phase_nxt;
      dsh_r <= dsh_nxt;    ish_r <= ish_nxt;     rsh_r <= rsh_nxt;    poll_r <= poll_nxt;
      last_r <= last_nxt;  sdi_r <= sdi_nxt;     sii_r <= sii_nxt;    sci_r <= sci_nxt;
    end
  end

  hvsp_queue #(.WIDTH($bits(res_t)), .DEPTH(DEPTH)) u_oq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (proc),
    .wr_data (res),
    .full    (oq_full),
    .rd_en   (pop),
    .rd_data (oq_data),
    .empty   (empty)
  );

  assign oq_res         = res_t'(oq_data);
  assign out_sdi        = oq_res.sdi;
  assign out_sii        = oq_res.sii;
  assign out_sci        = oq_res.sci;
  assign out_busy_res   = oq_res.busy;
  assign out_done_res   = oq_res.done;
  assign out_read_value = oq_res.read_value;
  assign out_rejected   = oq_res.rejected;

  a_done_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res.done) |-> !res.busy)
    else $error("completion reported while still busy");

  a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res.rejected) |-> (busy_r && (item.cls != CLS_TICK)))
    else $error("rejection without a busy command item");

  a_poll_only_write: assert property (@(posedge clk) disable iff (!rst_n)
    poll_r |-> (busy_r && (op_r == OP_WRF)))
    else $error("busy wait outside a fuse write");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r < BITS_PER_FRAME)
    else $error("bit counter past end of frame");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (!proc && $past(rst_n)) |=> $stable(busy_r) && $stable(bit_r))
    else $error("sequencer moved without taking an item");

endmodule
`default_nettype wire

/* sv/hvsp_fuse_programmer_master_core.sv */
`default_nettype none
// High-voltage serial programming master.
// Input channel (push/full): each request is either a command (in_kind = 0) that
// starts a signature read, a fuse read or a fuse write, or a tick (in_kind = 1)
// that advances the serial link by one pin update and carries the sampled SDO.
// A request is taken on a clock edge with push high and full low.
// Result channel (empty/pop): every request yields exactly one result holding
// the SDI, SII and SCI levels to drive, the busy and done flags, the last byte
// read and the rejected flag. The oldest result is shown while empty is low
// and is taken on a clock edge with pop high.
// A classifier stage writes requests into a two-entry queue; the sequencer
// takes one request per cycle from it while the result queue is not full and
// writes its result into a two-entry result queue, so a result shows only
// after its request has passed the request queue and the sequencer.
// When the receiver stops popping, the result queue fills, the sequencer
// holds, the request queue fills and full rises; nothing is lost.
// Reset (synchronous, active low) empties both queues and returns the
// sequencer to idle with all pins low and the read byte zero.
module hvsp_fuse_programmer_master_core #(
  parameter int IQ_DEPTH = hvsp_pkg::IQ_DEPTH,
  parameter int OQ_DEPTH = hvsp_pkg::OQ_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic       in_kind,
  input  wire logic [1:0] in_op,
  input  wire logic [1:0] in_fuse_select,
  input  wire logic [1:0] in_sig_index,
  input  wire logic [7:0] in_write_value,
  input  wire logic       in_sdo,
  output logic            empty,
  input  wire logic       pop,
  output logic            out_sdi,
  output logic            out_sii,
  output logic            out_sci,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic [7:0]      out_read_value,
  output logic            out_rejected
);
  import hvsp_pkg::*;

  // Classified request at the head of the request queue.
  item_t item;
  logic  item_valid;
  logic  item_take;

  hvsp_front #(.DEPTH(IQ_DEPTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_kind        (in_kind),
    .in_op          (in_op),
    .in_fuse_select (in_fuse_select),
    .in_sig_index   (in_sig_index),
    .in_write_value (in_write_value),
    .in_sdo         (in_sdo),
    .item           (item),
    .item_valid     (item_valid),
    .item_take      (item_take)
  );

  // The sequencer owns the frame counters, shift registers and pin levels.
  hvsp_back #(.DEPTH(OQ_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (item),
    .item_valid     (item_valid),
    .item_take      (item_take),
    .empty          (empty),
    .pop            (pop),
    .out_sdi        (out_sdi),
    .out_sii        (out_sii),
    .out_sci        (out_sci),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_read_value (out_read_value),
    .out_rejected   (out_rejected)
  );

endmodule
`default_nettype wire
